/* design/pvpid_pkg.sv */
// ----------------------------------------------------------------------------
// pvpid_pkg
// Shared types, constants and helpers for the position/velocity PID block.
// ----------------------------------------------------------------------------
package pvpid_pkg;

  localparam int unsigned AngW   = 32;           // Q16.16 angle, setpoint, effort
  localparam int unsigned OpW    = AngW + 1;     // differences of two angles
  localparam int unsigned GainW  = 24;           // Q8.16 gains
  localparam int unsigned ScaleW = 31;           // Q15.16 speed scale
  localparam int unsigned MulW   = ScaleW;       // multiplier bits scanned per product
  localparam int unsigned AccW   = OpW + 2;      // running partial product
  localparam int unsigned ProdW  = AccW + MulW;  // full product
  localparam int unsigned QW     = ProdW - 16;   // product after the Q16 shift
  localparam int unsigned IntW   = 25;           // integral, always inside +/-200.0
  localparam int unsigned ISumW  = QW + 1;       // integral update before clamp
  localparam int unsigned UW     = QW + 2;       // effort before saturation
  localparam int unsigned CntW   = $clog2(MulW + 1);
  localparam int unsigned CfgAW  = 3;
  localparam int unsigned QOne   = 65536;

  localparam logic signed [IntW-1:0] PosIntLim = IntW'(150 * QOne);
  localparam logic signed [IntW-1:0] VelIntLim = IntW'(200 * QOne);

  localparam logic [1:0] MODE_POS = 2'd0;
  localparam logic [1:0] MODE_VEL = 2'd1;

  typedef enum logic [CfgAW-1:0] {
    REG_LOOP_MODE   = 3'd0,
    REG_POS_KP      = 3'd1,
    REG_POS_KI      = 3'd2,
    REG_POS_KD      = 3'd3,
    REG_VEL_KP      = 3'd4,
    REG_VEL_KI      = 3'd5,
    REG_VEL_KD      = 3'd6,
    REG_SPEED_SCALE = 3'd7
  } reg_idx_e;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SPEED = 6'b000010,
    ST_MULI  = 6'b000100,
    ST_MULP  = 6'b001000,
    ST_MULD  = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

  // saturate to signed 32 bits
  function automatic logic signed [AngW-1:0] sat32(input logic signed [UW-1:0] v);
    logic [UW-AngW:0] top;
    top = v[UW-1:AngW-1];
    if (&top || ~|top) begin
      return v[AngW-1:0];
    end else if (v[UW-1]) begin
      return {1'b1, {(AngW-1){1'b0}}};
    end else begin
      return {1'b0, {(AngW-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [IntW-1:0] clamp_int(input logic signed [ISumW-1:0] s,
                                                       input logic signed [IntW-1:0] lim);
    logic signed [ISumW-1:0] hi;
    logic signed [ISumW-1:0] lo;
    hi = ISumW'(lim);
    lo = -hi;
    if (s > hi) begin
      return lim;
    end else if (s < lo) begin
      return -lim;
    end else begin
      return s[IntW-1:0];
    end
  endfunction

endpackage

/* design/position_velocity_pid_controller.sv */
// ----------------------------------------------------------------------------
// position_velocity_pid_controller
// Per-tick position / velocity PID with torque passthrough, bit-serial datapath.
// ----------------------------------------------------------------------------
// One transaction on the slave stream is one control tick (setpoint and measured
// angle, both signed Q16.16); one transaction on the master stream returns the
// saturated effort. All products go through a single shift-add multiplier that
// scans one bit of the gain (or speed scale) per cycle. Torque mode uses no
// product, position mode three products and velocity mode four. A new tick is
// taken as soon as the previous one has reached the output register, even
// while that result still waits to be taken. Registers are written through
// cfg_we_i / cfg_addr_i / cfg_wdata_i and should only change while no tick is
// in flight.
module position_velocity_pid_controller (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pvpid_pkg::CfgAW-1:0]  cfg_addr_i,
  input  logic [pvpid_pkg::ScaleW-1:0] cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [63:0]                  s_axis_tdata,   // setpoint, measured_angle
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [31:0]                  m_axis_tdata    // effort
);
  import pvpid_pkg::*;

  logic [1:0]        mode_q;
  logic [GainW-1:0]  pos_kp_q, pos_ki_q, pos_kd_q;
  logic [GainW-1:0]  vel_kp_q, vel_ki_q, vel_kd_q;
  logic [ScaleW-1:0] speed_scale_q;

  state_e                  state_q, state_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic [MulW-1:0]         mlo_q, mlo_d;
  logic signed [OpW-1:0]   a_q, a_d;
  logic signed [OpW-1:0]   e_q, e_d;
  logic signed [OpW-1:0]   dy_q, dy_d;
  logic signed [AngW-1:0]  r_q, r_d;
  logic signed [AngW-1:0]  prev_q, prev_d;
  logic signed [IntW-1:0]  int_q, int_d;
  logic signed [UW-1:0]    u_q, u_d;
  logic                    outv_q, outv_d;
  logic signed [AngW-1:0]  out_q, out_d;

  logic signed [AngW-1:0]  setpoint, meas;
  logic signed [AccW-1:0]  mul_add, mul_sum;
  logic signed [ProdW-1:0] prod;
  logic signed [QW-1:0]    q;
  logic                    mul_done, s_fire, is_vel;
  logic signed [OpW-1:0]   e_spd, e_pos, dy_new;
  logic signed [IntW-1:0]  int_new, int_lim;
  logic [MulW-1:0]         g_ki, g_kp, g_kd;

  assign setpoint = s_axis_tdata[31:0];
  assign meas     = s_axis_tdata[63:32];
  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign is_vel   = (mode_q == MODE_VEL);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = outv_q;
  assign m_axis_tdata  = out_q;

  // shift-add step: add the operand when the current multiplier bit is set,
  // then shift the pair right, the low half collecting product bits
  assign mul_add  = mlo_q[0] ? AccW'(a_q) : '0;
  assign mul_sum  = acc_q + mul_add;
  assign prod     = {acc_q, mlo_q};
  assign q        = prod[ProdW-1:16];
  assign mul_done = (cnt_q == CntW'(MulW));

  assign g_ki = MulW'(is_vel ? vel_ki_q : pos_ki_q);
  assign g_kp = MulW'(is_vel ? vel_kp_q : pos_kp_q);
  assign g_kd = MulW'(is_vel ? vel_kd_q : pos_kd_q);

  assign dy_new  = OpW'(meas) - OpW'(prev_q);
  assign e_pos   = OpW'(setpoint) - OpW'(meas);
  assign e_spd   = OpW'(r_q) - OpW'(sat32(UW'(q)));
  assign int_lim = is_vel ? VelIntLim : PosIntLim;
  assign int_new = clamp_int(ISumW'(int_q) + ISumW'(q), int_lim);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    mlo_d   = mlo_q;
    a_d     = a_q;
    e_d     = e_q;
    dy_d    = dy_q;
    r_d     = r_q;
    prev_d  = prev_q;
    int_d   = int_q;
    u_d     = u_q;
    outv_d  = outv_q && !m_axis_tready;
    out_d   = out_q;

    if (state_q != ST_IDLE && state_q != ST_FIN && !mul_done) begin
      acc_d = mul_sum >>> 1;
      mlo_d = {mul_sum[0], mlo_q[MulW-1:1]};
      cnt_d = cnt_q + 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          r_d    = setpoint;
          prev_d = meas;
          dy_d   = dy_new;
          acc_d  = '0;
          cnt_d  = '0;
          case (mode_q)
            MODE_POS: begin
              e_d     = e_pos;
              a_d     = e_pos;
              mlo_d   = g_ki;
              state_d = ST_MULI;
            end
            MODE_VEL: begin
              a_d     = dy_new;
              mlo_d   = MulW'(speed_scale_q);
              state_d = ST_SPEED;
            end
            default: begin
              u_d     = UW'(setpoint);
              state_d = ST_FIN;
            end
          endcase
        end
      end
      ST_SPEED: begin
        if (mul_done) begin
          e_d     = e_spd;
          a_d     = e_spd;
          mlo_d   = g_ki;
          acc_d   = '0;
          cnt_d   = '0;
          state_d = ST_MULI;
        end
      end
      ST_MULI: begin
        if (mul_done) begin
          int_d   = int_new;
          u_d     = UW'(int_new);
          a_d     = e_q;
          mlo_d   = g_kp;
          acc_d   = '0;
          cnt_d   = '0;
          state_d = ST_MULP;
        end
      end
      ST_MULP: begin
        if (mul_done) begin
          u_d     = u_q + UW'(q);
          a_d     = dy_q;
          mlo_d   = g_kd;
          acc_d   = '0;
          cnt_d   = '0;
          state_d = ST_MULD;
        end
      end
      ST_MULD: begin
        if (mul_done) begin
          u_d     = u_q - UW'(q);
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // wait here until the output register is free
        if (!outv_q || m_axis_tready) begin
          out_d   = sat32(u_q);
          outv_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      prev_q  <= '0;
      int_q   <= '0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      prev_q  <= prev_d;
      int_q   <= int_d;
      outv_q  <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mlo_q <= mlo_d;
    a_q   <= a_d;
    e_q   <= e_d;
    dy_q  <= dy_d;
    r_q   <= r_d;
    u_q   <= u_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= '0;
      pos_kp_q      <= '0;
      pos_ki_q      <= '0;
      pos_kd_q      <= '0;
      vel_kp_q      <= '0;
      vel_ki_q      <= '0;
      vel_kd_q      <= '0;
      speed_scale_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_LOOP_MODE:   mode_q        <= cfg_wdata_i[1:0];
        REG_POS_KP:      pos_kp_q      <= cfg_wdata_i[GainW-1:0];
        REG_POS_KI:      pos_ki_q      <= cfg_wdata_i[GainW-1:0];
        REG_POS_KD:      pos_kd_q      <= cfg_wdata_i[GainW-1:0];
        REG_VEL_KP:      vel_kp_q      <= cfg_wdata_i[GainW-1:0];
        REG_VEL_KI:      vel_ki_q      <= cfg_wdata_i[GainW-1:0];
        REG_VEL_KD:      vel_kd_q      <= cfg_wdata_i[GainW-1:0];
        REG_SPEED_SCALE: speed_scale_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

endmodule

/* design/pvpid_checker.sv */
// ----------------------------------------------------------------------------
// pvpid_checker
// Port-level checks for the position/velocity PID block, bound to the top level.
// ----------------------------------------------------------------------------
module pvpid_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

  // the block is busy right after taking a tick
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a transaction");

  // a new result only appears at the end of a tick's work
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a tick in progress");

  // results are loaded only out of the busy phase, so the input side is open again
  a_ready_with_new_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("input not ready after a result was produced");

endmodule

bind position_velocity_pid_controller pvpid_checker u_pvpid_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the position/velocity PID controller.
// Writes register settings while the block is idle, streams control ticks with
// bursty valid and a stalling ready, and predicts each effort with a
// 64-bit integer model of the PID. Every effort is compared in order.
// ----------------------------------------------------------------------------
module testbench;
  import pvpid_pkg::*;

  localparam logic [1:0] MODE_TRQ   = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;   // unused code, acts as torque

  localparam longint S32Max      = 64'sd2147483647;
  localparam longint S32Min      = -64'sd2147483648;
  localparam longint PosIntClamp = 64'sd150 * 64'sd65536;
  localparam longint VelIntClamp = 64'sd200 * 64'sd65536;

  localparam int CycleLimit = 600000;
  localparam int HoldAt     = 300;   // results taken before the long hold-off
  localparam int HoldLen    = 700;

  typedef struct packed {
    logic signed [31:0] setpoint;
    logic signed [31:0] angle;
  } tick_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgAW-1:0]     cfg_addr_i;
  logic [ScaleW-1:0]    cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [63:0]          s_axis_tdata;   // setpoint, measured_angle
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [31:0]          m_axis_tdata;   // effort

  // register shadow and controller state of the predictor
  logic [1:0]           mode_r;
  logic [23:0]          pos_kp, pos_ki, pos_kd;
  logic [23:0]          vel_kp, vel_ki, vel_kd;
  logic [30:0]          speed_scale_r;
  longint               integ_acc;
  longint               prev_angle;

  tick_t                tick_q[$];
  logic [31:0]          effort_q[$];
  logic [30:0]          cfg_plan[8];
  logic signed [31:0]   walk_angle;
  int                   err_count;
  int                   cycle_cnt;

  tick_t                drv_tick;
  int                   burst_left, gap_left;
  int                   rx_taken, hold_left, rx_span, rx_period, rx_duty, rx_tick;
  bit                   hold_done;

  position_velocity_pid_controller u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // ---------------- predictor ----------------

  // floor of (x * k) / 2^16
  function automatic longint q16_mul(longint x, longint k);
    return (x * k) >>> 16;
  endfunction

  function automatic longint sat_s32(longint v);
    if (v > S32Max) return S32Max;
    if (v < S32Min) return S32Min;
    return v;
  endfunction

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic [31:0] tick_effort(logic signed [31:0] sp, logic signed [31:0] ang);
    longint dy, err, spd, u;
    dy = longint'(ang) - prev_angle;
    case (mode_r)
      MODE_POS: begin
        err = longint'(sp) - longint'(ang);
        integ_acc = clamp_sym(integ_acc + q16_mul(err, longint'(pos_ki)), PosIntClamp);
        u = q16_mul(err, longint'(pos_kp)) + integ_acc - q16_mul(dy, longint'(pos_kd));
      end
      MODE_VEL: begin
        spd = sat_s32(q16_mul(dy, longint'(speed_scale_r)));
        err = longint'(sp) - spd;
        integ_acc = clamp_sym(integ_acc + q16_mul(err, longint'(vel_ki)), VelIntClamp);
        u = q16_mul(err, longint'(vel_kp)) + integ_acc - q16_mul(dy, longint'(vel_kd));
      end
      default: begin
        u = longint'(sp);
      end
    endcase
    prev_angle = longint'(ang);
    return 32'(sat_s32(u));
  endfunction

  function automatic void shadow_write(reg_idx_e idx, logic [30:0] v);
    case (idx)
      REG_LOOP_MODE:   mode_r = v[1:0];
      REG_POS_KP:      pos_kp = v[23:0];
      REG_POS_KI:      pos_ki = v[23:0];
      REG_POS_KD:      pos_kd = v[23:0];
      REG_VEL_KP:      vel_kp = v[23:0];
      REG_VEL_KI:      vel_ki = v[23:0];
      REG_VEL_KD:      vel_kd = v[23:0];
      REG_SPEED_SCALE: speed_scale_r = v;
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    err_count++;
  endtask

  // ---------------- stimulus helpers ----------------

  // writes every register from cfg_plan, one per cycle, then drops the enable
  task automatic apply_plan();
    for (int i = 0; i < 8; i++) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= CfgAW'(i);
      cfg_wdata_i <= cfg_plan[i];
      shadow_write(reg_idx_e'(i[2:0]), cfg_plan[i]);
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic push_tick(logic [31:0] sp, logic [31:0] ang);
    tick_t t;
    t.setpoint = sp;
    t.angle    = ang;
    tick_q.push_back(t);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (tick_q.size() != 0 || s_axis_tvalid || effort_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  // gain with random bits above the register width
  function automatic logic [30:0] rand_gain();
    logic [23:0] g;
    case ($urandom_range(0, 5))
      0:       g = 24'h0;
      1:       g = 24'hFF_FFFF;
      2, 3:    g = 24'($urandom_range(0, 32'h4_0000));
      4:       g = 24'($urandom_range(0, 32'h1000));
      default: g = 24'($urandom);
    endcase
    return {7'($urandom), g};
  endfunction

  function automatic logic [30:0] rand_scale();
    case ($urandom_range(0, 4))
      0:       return 31'h0;
      1:       return 31'h7FFF_FFFF;
      2:       return 31'($urandom);
      default: return 31'($urandom_range(1, 3000)) << 16;
    endcase
  endfunction

  function automatic tick_t next_tick(logic [1:0] mode);
    tick_t t;
    int    span;
    case ($urandom_range(0, 9))
      0: begin
        t.setpoint = $urandom;
        t.angle    = $urandom;
      end
      1: begin
        t.setpoint = $urandom;
        t.angle    = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
      default: begin
        // shaft follows a random walk, setpoint near it or a modest speed target
        case ($urandom_range(0, 2))
          0:       span = 'h100;
          1:       span = 'h2_0000;
          default: span = 'h80_0000;
        endcase
        walk_angle = walk_angle + (int'($urandom_range(0, 2 * span)) - span);
        t.angle    = walk_angle;
        if (mode == MODE_VEL) begin
          t.setpoint = int'($urandom_range(0, 32'h200_0000)) - 'h100_0000;
        end else begin
          t.setpoint = walk_angle + (int'($urandom_range(0, 2 * span)) - span);
        end
      end
    endcase
    return t;
  endfunction

  // ---------------- sender ----------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0 || tick_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        s_axis_tvalid <= 1'b0;
      end else begin
        drv_tick = tick_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {drv_tick.angle, drv_tick.setpoint};
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end
    end
  end

  // ---------------- receiver ----------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_taken  = 0;
      hold_left = 0;
      hold_done = 1'b0;
      rx_span   = 0;
      rx_period = 1;
      rx_duty   = 1;
      rx_tick   = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) rx_taken++;
      if (!hold_done && rx_taken == HoldAt) begin
        hold_done = 1'b1;
        hold_left = HoldLen;
      end
      if (rx_span == 0) begin
        rx_span   = $urandom_range(50, 400);
        rx_period = $urandom_range(1, 8);
        rx_duty   = $urandom_range(1, rx_period);
        rx_tick   = 0;
      end else begin
        rx_span--;
        rx_tick++;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (rx_tick % rx_period) < rx_duty;
      end
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      effort_q.push_back(tick_effort(s_axis_tdata[31:0], s_axis_tdata[63:32]));
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (effort_q.size() == 0) begin
        report_mismatch("effort with no tick pending", m_axis_tdata, 32'h0);
      end else begin
        want = effort_q.pop_front();
        if (m_axis_tdata !== want) report_mismatch("effort", m_axis_tdata, want);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------- sequence ----------------

  initial begin
    logic [1:0] phase_mode [6];
    tick_t      t;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    err_count     = 0;
    cycle_cnt     = 0;
    walk_angle    = '0;
    mode_r        = MODE_POS;
    pos_kp = '0; pos_ki = '0; pos_kd = '0;
    vel_kp = '0; vel_ki = '0; vel_kd = '0;
    speed_scale_r = '0;
    integ_acc     = 0;
    prev_angle    = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // position loop, first tick sees the whole angle as derivative
    cfg_plan = '{31'h7FFF_FFFC, 31'h00FF_FFFF, 31'h0001_0000, 31'h00FF_FFFF,
                 31'h0, 31'h0, 31'h0, 31'h0};
    apply_plan();
    push_tick(32'h0000_0000, 32'h7FFF_FFFF);
    push_tick(32'h8000_0000, 32'h7FFF_FFFF);
    push_tick(32'h7FFF_FFFF, 32'h8000_0000);
    push_tick(32'h0000_0000, 32'h0000_0000);
    push_tick(32'h0001_0000, 32'h0000_0000);
    push_tick(32'hFFFF_FFFF, 32'h0000_0000);
    push_tick(32'h0000_0001, 32'hFFFF_FFFF);
    wait_drained();

    // velocity loop with full scale: speed and effort saturate
    cfg_plan = '{31'h0000_0001, 31'h0, 31'h0, 31'h0,
                 31'h00FF_FFFF, 31'h00FF_FFFF, 31'h0000_8000, 31'h7FFF_FFFF};
    apply_plan();
    push_tick(32'h0000_0000, 32'h7FFF_FFFF);
    push_tick(32'h7FFF_FFFF, 32'h8000_0000);
    push_tick(32'h0000_0000, 32'h8000_0001);
    push_tick(32'h8000_0000, 32'h8000_0001);
    push_tick(32'h1234_5678, 32'h8000_0000);
    push_tick(32'hFFFB_0000, 32'h8000_0003);
    wait_drained();

    // torque passthrough keeps the integral
    cfg_plan = '{31'h0000_0002, 31'h00FF_FFFF, 31'h00FF_FFFF, 31'h00FF_FFFF,
                 31'h00FF_FFFF, 31'h00FF_FFFF, 31'h00FF_FFFF, 31'h0};
    apply_plan();
    push_tick(32'h7FFF_FFFF, 32'h1111_1111);
    push_tick(32'h8000_0000, 32'hEEEE_EEEE);
    push_tick(32'h0000_0000, 32'h7FFF_FFFF);
    push_tick(32'hFFFF_FFFF, 32'h8000_0000);
    wait_drained();

    // spare mode code behaves as torque
    cfg_plan[REG_LOOP_MODE] = {29'($urandom), MODE_SPARE};
    apply_plan();
    push_tick(32'h5A5A_5A5A, $urandom);
    push_tick(32'h8000_0000, $urandom);
    push_tick(32'h7FFF_FFFF, 32'h0000_0000);
    wait_drained();

    // random phases; integral carries across mode changes
    phase_mode = '{MODE_VEL, MODE_POS, MODE_VEL, MODE_TRQ, MODE_POS, MODE_SPARE};
    foreach (phase_mode[p]) begin
      cfg_plan[REG_LOOP_MODE] = {29'($urandom), phase_mode[p]};
      for (int i = 1; i < 7; i++) cfg_plan[i] = rand_gain();
      cfg_plan[REG_SPEED_SCALE] = rand_scale();
      apply_plan();
      for (int n = 0; n < ((phase_mode[p] < MODE_TRQ) ? 180 : 60); n++) begin
        t = next_tick(phase_mode[p]);
        tick_q.push_back(t);
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
